// ===== rtl/core/mmpt_pkg.sv =====
package mmpt_pkg;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] bus_address;
      logic [7:0]  write_byte;
      logic [7:0]  key_code;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] result_byte;
      logic       last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      CMD_READ_LOW,
      CMD_READ_HIGH,
      CMD_READ_ROM,
      CMD_READ_KD,
      CMD_READ_KC,
      CMD_READ_DD,
      CMD_READ_DC,
      CMD_READ_ZERO,
      CMD_WRITE_LOW,
      CMD_WRITE_HIGH,
      CMD_WRITE_KD,
      CMD_WRITE_KC,
      CMD_WRITE_DC,
      CMD_DISPLAY,
      CMD_KEY,
      CMD_SPARE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  address;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      logic    pair;
      rsp_type first;
      rsp_type second;
   } rsp_write_type;

   localparam logic [1:0] OpRead  = 2'd0;
   localparam logic [1:0] OpWrite = 2'd1;
   localparam logic [1:0] OpKey   = 2'd2;

   localparam logic [3:0] PageLowRam  = 4'h0;
   localparam logic [3:0] PageHighRam = 4'hE;
   localparam logic [3:0] PageRom     = 4'hF;

   localparam logic [15:0] KbdDataAddr  = 16'hD010;
   localparam logic [15:0] KbdCtrlAddr  = 16'hD011;
   localparam logic [15:0] DispDataAddr = 16'hD012;
   localparam logic [15:0] DispCtrlAddr = 16'hD013;
   localparam logic [15:0] RomBase      = 16'hFF00;

   localparam logic [7:0] CharCr       = 8'h8D;
   localparam logic [7:0] CharRubout   = 8'hDF;
   localparam logic [7:0] CharLf       = 8'h0A;
   localparam logic [7:0] CharBs       = 8'h08;
   localparam logic [7:0] CharDel      = 8'h7F;
   localparam logic [7:0] CharUnder    = 8'h5F;
   localparam logic [7:0] OutCr        = 8'h0D;
   localparam logic [7:0] OutLf        = 8'h0A;
   localparam logic [7:0] OutBs        = 8'h08;
   localparam logic [7:0] Low7Mask     = 8'h7F;
   localparam logic [7:0] StrobeBit    = 8'h80;

   localparam logic KindRead = 1'b0;
   localparam logic KindTerm = 1'b1;

   localparam int RspQueueDepth = 4;
   localparam int RspCountWidth = $clog2(RspQueueDepth + 1);

   localparam logic [7:0] MonitorRom [256] = '{
      8'hD8,8'h58,8'hA0,8'h7F,8'h8C,8'h12,8'hD0,8'hA9,
      8'hA7,8'h8D,8'h11,8'hD0,8'h8D,8'h13,8'hD0,8'hC9,
      8'hDF,8'hF0,8'h13,8'hC9,8'h9B,8'hF0,8'h03,8'hC8,
      8'h10,8'h0F,8'hA9,8'hDC,8'h20,8'hEF,8'hFF,8'hA9,
      8'h8D,8'h20,8'hEF,8'hFF,8'hA0,8'h01,8'h88,8'h30,
      8'hF6,8'hAD,8'h11,8'hD0,8'h10,8'hFB,8'hAD,8'h10,
      8'hD0,8'h99,8'h00,8'h02,8'h20,8'hEF,8'hFF,8'hC9,
      8'h8D,8'hD0,8'hD4,8'hA0,8'hFF,8'hA9,8'h00,8'hAA,
      8'h0A,8'h85,8'h2B,8'hC8,8'hB9,8'h00,8'h02,8'hC9,
      8'h8D,8'hF0,8'hD4,8'hC9,8'hAE,8'h90,8'hF4,8'hF0,
      8'hF0,8'hC9,8'hBA,8'hF0,8'hEB,8'hC9,8'hD2,8'hF0,
      8'h3B,8'h86,8'h28,8'h86,8'h29,8'h84,8'h2A,8'hB9,
      8'h00,8'h02,8'h49,8'hB0,8'hC9,8'h0A,8'h90,8'h06,
      8'h69,8'h88,8'hC9,8'hFA,8'h90,8'h11,8'h0A,8'h0A,
      8'h0A,8'h0A,8'hA2,8'h04,8'h0A,8'h26,8'h28,8'h26,
      8'h29,8'hCA,8'hD0,8'hF8,8'hC8,8'hD0,8'hE0,8'hC4,
      8'h2A,8'hF0,8'h97,8'h24,8'h2B,8'h50,8'h10,8'hA5,
      8'h28,8'h81,8'h26,8'hE6,8'h26,8'hD0,8'hB5,8'hE6,
      8'h27,8'h4C,8'h44,8'hFF,8'h6C,8'h24,8'h00,8'h30,
      8'h2B,8'hA2,8'h02,8'hB5,8'h27,8'h95,8'h25,8'h95,
      8'h23,8'hCA,8'hD0,8'hF7,8'hD0,8'h14,8'hA9,8'h8D,
      8'h20,8'hEF,8'hFF,8'hA5,8'h25,8'h20,8'hDC,8'hFF,
      8'hA5,8'h24,8'h20,8'hDC,8'hFF,8'hA9,8'hBA,8'h20,
      8'hEF,8'hFF,8'hA9,8'hA0,8'h20,8'hEF,8'hFF,8'hA1,
      8'h24,8'h20,8'hDC,8'hFF,8'h86,8'h2B,8'hA5,8'h24,
      8'hC5,8'h28,8'hA5,8'h25,8'hE5,8'h29,8'hB0,8'hC1,
      8'hE6,8'h24,8'hD0,8'h02,8'hE6,8'h25,8'hA5,8'h24,
      8'h29,8'h07,8'h10,8'hC8,8'h48,8'h4A,8'h4A,8'h4A,
      8'h4A,8'h20,8'hE5,8'hFF,8'h68,8'h29,8'h0F,8'h09,
      8'hB0,8'hC9,8'hBA,8'h90,8'h02,8'h69,8'h06,8'h2C,
      8'h12,8'hD0,8'h30,8'hFB,8'h8D,8'h12,8'hD0,8'h60,
      8'h00,8'h00,8'h00,8'h0F,8'h00,8'hFF,8'h00,8'h00
   };

endpackage

// ===== rtl/core/memory_map_with_pia_terminal.sv =====
// a read or display result passes the front queue, stage-two registers and result queue
// throughput: one transfer per cycle while results drain; the back end issues a command
//   only when the 4-entry result queue has room for two more results
// reset: synchronous, active high; clears both queues and the four terminal registers
// ram banks hold no reset value and get no clearing pass; rom is a constant table
module memory_map_with_pia_terminal #(
   parameter int RAM_BANK_DEPTH = 4096,
   parameter int ROM_DEPTH      = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mmpt_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mmpt_pkg::rsp_type rsp_data
);

   logic                               cmd_valid;
   mmpt_pkg::cmd_type                  cmd;
   logic                               cmd_pop;
   logic [mmpt_pkg::RspCountWidth-1:0] rsp_count;
   mmpt_pkg::rsp_write_type            rsp_write;

   mmpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   mmpt_back #(
      .RAM_BANK_DEPTH (RAM_BANK_DEPTH),
      .ROM_DEPTH      (ROM_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_write (rsp_write)
   );

   mmpt_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_write (rsp_write),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_count (rsp_count)
   );

endmodule

// ===== rtl/core/mmpt_front.sv =====
module mmpt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mmpt_pkg::req_type req_data,
   output logic             cmd_valid,
   output mmpt_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   mmpt_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   mmpt_pkg::cmd_type dec;
   logic              enq;
   logic              push_fire;
   logic              pop_fire;
   logic [3:0]        page;
   logic [7:0]        key_mapped;

   assign page = req_data.bus_address[15:12];

   // classify the transfer into a back-end command; unmapped writes, line-feed keys and spare opcodes are dropped
   always_comb begin
      dec.kind    = mmpt_pkg::CMD_READ_ZERO;
      dec.address = req_data.bus_address;
      dec.data    = req_data.write_byte;
      enq         = 1'b0;
      key_mapped  = req_data.key_code;
      unique case (req_data.opcode)
         mmpt_pkg::OpRead: begin
            enq = 1'b1;
            priority if (page == mmpt_pkg::PageLowRam) begin
               dec.kind = mmpt_pkg::CMD_READ_LOW;
            end else if (page == mmpt_pkg::PageHighRam) begin
               dec.kind = mmpt_pkg::CMD_READ_HIGH;
            end else if (page == mmpt_pkg::PageRom) begin
               dec.kind = mmpt_pkg::CMD_READ_ROM;
            end else if (req_data.bus_address == mmpt_pkg::KbdDataAddr) begin
               dec.kind = mmpt_pkg::CMD_READ_KD;
            end else if (req_data.bus_address == mmpt_pkg::KbdCtrlAddr) begin
               dec.kind = mmpt_pkg::CMD_READ_KC;
            end else if (req_data.bus_address == mmpt_pkg::DispDataAddr) begin
               dec.kind = mmpt_pkg::CMD_READ_DD;
            end else if (req_data.bus_address == mmpt_pkg::DispCtrlAddr) begin
               dec.kind = mmpt_pkg::CMD_READ_DC;
            end else begin
               dec.kind = mmpt_pkg::CMD_READ_ZERO;
            end
         end
         mmpt_pkg::OpWrite: begin
            enq = 1'b1;
            priority if (page == mmpt_pkg::PageLowRam) begin
               dec.kind = mmpt_pkg::CMD_WRITE_LOW;
            end else if (page == mmpt_pkg::PageHighRam) begin
               dec.kind = mmpt_pkg::CMD_WRITE_HIGH;
            end else if (req_data.bus_address == mmpt_pkg::KbdDataAddr) begin
               dec.kind = mmpt_pkg::CMD_WRITE_KD;
            end else if (req_data.bus_address == mmpt_pkg::KbdCtrlAddr) begin
               dec.kind = mmpt_pkg::CMD_WRITE_KC;
            end else if (req_data.bus_address == mmpt_pkg::DispDataAddr) begin
               dec.kind = mmpt_pkg::CMD_DISPLAY;
            end else if (req_data.bus_address == mmpt_pkg::DispCtrlAddr) begin
               dec.kind = mmpt_pkg::CMD_WRITE_DC;
            end else begin
               enq = 1'b0;
            end
         end
         mmpt_pkg::OpKey: begin
            if (req_data.key_code == mmpt_pkg::CharBs ||
                req_data.key_code == mmpt_pkg::CharDel) begin
               key_mapped = mmpt_pkg::CharUnder;
            end
            dec.kind = mmpt_pkg::CMD_KEY;
            dec.data = key_mapped | mmpt_pkg::StrobeBit;
            enq      = (req_data.key_code != mmpt_pkg::CharLf);
         end
         default: begin
            enq = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign push_fire = req_push && !req_full && enq;
   assign pop_fire  = cmd_pop && cmd_valid;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push_fire ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop_fire ? !rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + 2'(push_fire) - 2'(pop_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== rtl/core/mmpt_back.sv =====
module mmpt_back #(
   parameter int RAM_BANK_DEPTH = 4096,
   parameter int ROM_DEPTH      = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   input  mmpt_pkg::cmd_type                  cmd,
   output logic                               cmd_pop,
   input  logic [mmpt_pkg::RspCountWidth-1:0] rsp_count,
   output mmpt_pkg::rsp_write_type            rsp_write
);

   localparam int RamAw = $clog2(RAM_BANK_DEPTH);
   localparam int RomAw = $clog2(ROM_DEPTH);

   typedef enum logic [1:0] {
      SRC_BYTE,
      SRC_LOW,
      SRC_HIGH
   } src_type;

   logic [7:0] low_ram  [RAM_BANK_DEPTH];
   logic [7:0] high_ram [RAM_BANK_DEPTH];
   logic [7:0] low_rd_ff;
   logic [7:0] high_rd_ff;

   logic [7:0] key_data_ff, key_data_in;
   logic [7:0] key_control_ff, key_control_in;
   logic [7:0] display_data_ff, display_data_in;
   logic [7:0] display_control_ff, display_control_in;

   logic       s2_valid_ff, s2_valid_in;
   logic       s2_pair_ff, s2_pair_in;
   logic       s2_kind_ff, s2_kind_in;
   src_type    s2_src_ff, s2_src_in;
   logic [7:0] s2_byte_ff, s2_byte_in;

   logic [RamAw-1:0] ram_idx;
   logic [15:0]      rom_off;
   logic [11:0]      rom_idx;
   logic [7:0]       rom_byte;
   logic [3:0]       slots_used;
   logic             issue;
   logic [7:0]       first_byte;

   assign ram_idx  = cmd.address[RamAw-1:0];
   assign rom_off  = cmd.address - mmpt_pkg::RomBase;
   assign rom_idx  = 12'(rom_off[RomAw-1:0]);
   assign rom_byte = (rom_idx[11:8] == 4'd0) ? mmpt_pkg::MonitorRom[rom_idx[7:0]] : 8'd0;

   // room for the stage-two results plus two more
   assign slots_used = 4'(rsp_count) +
                       (s2_valid_ff ? (s2_pair_ff ? 4'd2 : 4'd1) : 4'd0);
   assign issue      = cmd_valid && (slots_used <= 4'(mmpt_pkg::RspQueueDepth - 2));
   assign cmd_pop    = issue;

   always_ff @(posedge clock) begin
      if (issue && cmd.kind == mmpt_pkg::CMD_WRITE_LOW) begin
         low_ram[ram_idx] <= cmd.data;
      end
      low_rd_ff <= low_ram[ram_idx];
   end

   always_ff @(posedge clock) begin
      if (issue && cmd.kind == mmpt_pkg::CMD_WRITE_HIGH) begin
         high_ram[ram_idx] <= cmd.data;
      end
      high_rd_ff <= high_ram[ram_idx];
   end

   always_comb begin
      s2_valid_in        = 1'b0;
      s2_pair_in         = s2_pair_ff;
      s2_kind_in         = s2_kind_ff;
      s2_src_in          = s2_src_ff;
      s2_byte_in         = s2_byte_ff;
      key_data_in        = key_data_ff;
      key_control_in     = key_control_ff;
      display_data_in    = display_data_ff;
      display_control_in = display_control_ff;
      if (issue) begin
         s2_src_in  = SRC_BYTE;
         s2_kind_in = mmpt_pkg::KindRead;
         s2_pair_in = 1'b0;
         s2_byte_in = 8'd0;
         unique case (cmd.kind)
            mmpt_pkg::CMD_READ_LOW: begin
               s2_valid_in = 1'b1;
               s2_src_in   = SRC_LOW;
            end
            mmpt_pkg::CMD_READ_HIGH: begin
               s2_valid_in = 1'b1;
               s2_src_in   = SRC_HIGH;
            end
            mmpt_pkg::CMD_READ_ROM: begin
               s2_valid_in = 1'b1;
               s2_byte_in  = rom_byte;
            end
            mmpt_pkg::CMD_READ_KD: begin
               s2_valid_in       = 1'b1;
               s2_byte_in        = key_data_ff;
               key_control_in[7] = 1'b0;
            end
            mmpt_pkg::CMD_READ_KC: begin
               s2_valid_in = 1'b1;
               s2_byte_in  = key_control_ff;
            end
            mmpt_pkg::CMD_READ_DD: begin
               s2_valid_in = 1'b1;
               s2_byte_in  = display_data_ff;
            end
            mmpt_pkg::CMD_READ_DC: begin
               s2_valid_in = 1'b1;
               s2_byte_in  = display_control_ff;
            end
            mmpt_pkg::CMD_READ_ZERO: begin
               s2_valid_in = 1'b1;
            end
            mmpt_pkg::CMD_WRITE_KD: begin
               key_data_in = cmd.data;
            end
            mmpt_pkg::CMD_WRITE_KC: begin
               key_control_in = cmd.data;
            end
            mmpt_pkg::CMD_WRITE_DC: begin
               display_control_in = cmd.data;
            end
            mmpt_pkg::CMD_DISPLAY: begin
               display_data_in = cmd.data & mmpt_pkg::Low7Mask;
               s2_valid_in     = 1'b1;
               s2_kind_in      = mmpt_pkg::KindTerm;
               priority if (cmd.data == mmpt_pkg::CharCr) begin
                  s2_pair_in = 1'b1;
                  s2_byte_in = mmpt_pkg::OutCr;
               end else if (cmd.data == mmpt_pkg::CharRubout) begin
                  s2_byte_in = mmpt_pkg::OutBs;
               end else begin
                  s2_byte_in = cmd.data & mmpt_pkg::Low7Mask;
               end
            end
            mmpt_pkg::CMD_KEY: begin
               key_data_in       = cmd.data;
               key_control_in[7] = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff        <= 1'b0;
         key_data_ff        <= 8'd0;
         key_control_ff     <= 8'd0;
         display_data_ff    <= 8'd0;
         display_control_ff <= 8'd0;
      end else begin
         s2_valid_ff        <= s2_valid_in;
         key_data_ff        <= key_data_in;
         key_control_ff     <= key_control_in;
         display_data_ff    <= display_data_in;
         display_control_ff <= display_control_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_pair_ff <= s2_pair_in;
      s2_kind_ff <= s2_kind_in;
      s2_src_ff  <= s2_src_in;
      s2_byte_ff <= s2_byte_in;
   end

   always_comb begin
      unique case (s2_src_ff)
         SRC_LOW:  first_byte = low_rd_ff;
         SRC_HIGH: first_byte = high_rd_ff;
         default:  first_byte = s2_byte_ff;
      endcase
   end

   assign rsp_write.valid              = s2_valid_ff;
   assign rsp_write.pair               = s2_pair_ff;
   assign rsp_write.first.result_kind  = s2_kind_ff;
   assign rsp_write.first.result_byte  = first_byte;
   assign rsp_write.first.last_of_run  = !s2_pair_ff;
   assign rsp_write.second.result_kind = mmpt_pkg::KindTerm;
   assign rsp_write.second.result_byte = mmpt_pkg::OutLf;
   assign rsp_write.second.last_of_run = 1'b1;

endmodule

// ===== rtl/core/mmpt_rsp_queue.sv =====
module mmpt_rsp_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  mmpt_pkg::rsp_write_type            rsp_write,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output mmpt_pkg::rsp_type                  rsp_data,
   output logic [mmpt_pkg::RspCountWidth-1:0] rsp_count
);

   localparam int PtrW = $clog2(mmpt_pkg::RspQueueDepth);
   localparam int CntW = mmpt_pkg::RspCountWidth;

   mmpt_pkg::rsp_type entry_ff [mmpt_pkg::RspQueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [PtrW-1:0]   wr_next;
   logic              pop_fire;
   logic [CntW-1:0]   push_n;

   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign rsp_count = count_ff;
   assign pop_fire  = rsp_pop && !rsp_empty;
   assign wr_next   = wr_ptr_ff + PtrW'(1);
   assign push_n    = !rsp_write.valid ? CntW'(0) : (rsp_write.pair ? CntW'(2) : CntW'(1));

   assign wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(pop_fire);
   assign count_in  = count_ff + push_n - CntW'(pop_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_write.valid) begin
         entry_ff[wr_ptr_ff] <= rsp_write.first;
         if (rsp_write.pair) begin
            entry_ff[wr_next] <= rsp_write.second;
         end
      end
   end

endmodule

// ===== rtl/core/mmpt_checker.sv =====
module mmpt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input mmpt_pkg::req_type req_data,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input mmpt_pkg::rsp_type rsp_data
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed");

   // read data always ends its run
   a_read_single: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.result_kind == mmpt_pkg::KindRead |-> rsp_data.last_of_run)
      else $error("read result not last of run");

   // only a carriage return opens a two-result run
   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.last_of_run |->
         rsp_data.result_kind == mmpt_pkg::KindTerm &&
         rsp_data.result_byte == mmpt_pkg::OutCr)
      else $error("unexpected first result of a pair");

   // the line feed follows its carriage return once taken
   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_data.last_of_run |=>
         !rsp_empty && rsp_data.result_byte == mmpt_pkg::OutLf && rsp_data.last_of_run)
      else $error("line feed missing after carriage return");

endmodule

bind memory_map_with_pia_terminal mmpt_checker u_checker (.*);

// ===== sim/memory_map_with_pia_terminal_tb.sv =====
`timescale 1ns / 1ps

module memory_map_with_pia_terminal_tb;

   localparam logic [1:0] OpSpare = 2'd3;
   localparam int NumDirected = 28;
   localparam int NumAccesses = 370;

   typedef struct packed {
      mmpt_pkg::req_type req;
      logic [1:0]        n_typed;
      logic              kind;
      logic [7:0]        byte0;
      logic [7:0]        byte1;
   } stim_row_type;

   localparam logic [7:0] RomImage [256] = '{
      8'hD8,8'h58,8'hA0,8'h7F,8'h8C,8'h12,8'hD0,8'hA9,
      8'hA7,8'h8D,8'h11,8'hD0,8'h8D,8'h13,8'hD0,8'hC9,
      8'hDF,8'hF0,8'h13,8'hC9,8'h9B,8'hF0,8'h03,8'hC8,
      8'h10,8'h0F,8'hA9,8'hDC,8'h20,8'hEF,8'hFF,8'hA9,
      8'h8D,8'h20,8'hEF,8'hFF,8'hA0,8'h01,8'h88,8'h30,
      8'hF6,8'hAD,8'h11,8'hD0,8'h10,8'hFB,8'hAD,8'h10,
      8'hD0,8'h99,8'h00,8'h02,8'h20,8'hEF,8'hFF,8'hC9,
      8'h8D,8'hD0,8'hD4,8'hA0,8'hFF,8'hA9,8'h00,8'hAA,
      8'h0A,8'h85,8'h2B,8'hC8,8'hB9,8'h00,8'h02,8'hC9,
      8'h8D,8'hF0,8'hD4,8'hC9,8'hAE,8'h90,8'hF4,8'hF0,
      8'hF0,8'hC9,8'hBA,8'hF0,8'hEB,8'hC9,8'hD2,8'hF0,
      8'h3B,8'h86,8'h28,8'h86,8'h29,8'h84,8'h2A,8'hB9,
      8'h00,8'h02,8'h49,8'hB0,8'hC9,8'h0A,8'h90,8'h06,
      8'h69,8'h88,8'hC9,8'hFA,8'h90,8'h11,8'h0A,8'h0A,
      8'h0A,8'h0A,8'hA2,8'h04,8'h0A,8'h26,8'h28,8'h26,
      8'h29,8'hCA,8'hD0,8'hF8,8'hC8,8'hD0,8'hE0,8'hC4,
      8'h2A,8'hF0,8'h97,8'h24,8'h2B,8'h50,8'h10,8'hA5,
      8'h28,8'h81,8'h26,8'hE6,8'h26,8'hD0,8'hB5,8'hE6,
      8'h27,8'h4C,8'h44,8'hFF,8'h6C,8'h24,8'h00,8'h30,
      8'h2B,8'hA2,8'h02,8'hB5,8'h27,8'h95,8'h25,8'h95,
      8'h23,8'hCA,8'hD0,8'hF7,8'hD0,8'h14,8'hA9,8'h8D,
      8'h20,8'hEF,8'hFF,8'hA5,8'h25,8'h20,8'hDC,8'hFF,
      8'hA5,8'h24,8'h20,8'hDC,8'hFF,8'hA9,8'hBA,8'h20,
      8'hEF,8'hFF,8'hA9,8'hA0,8'h20,8'hEF,8'hFF,8'hA1,
      8'h24,8'h20,8'hDC,8'hFF,8'h86,8'h2B,8'hA5,8'h24,
      8'hC5,8'h28,8'hA5,8'h25,8'hE5,8'h29,8'hB0,8'hC1,
      8'hE6,8'h24,8'hD0,8'h02,8'hE6,8'h25,8'hA5,8'h24,
      8'h29,8'h07,8'h10,8'hC8,8'h48,8'h4A,8'h4A,8'h4A,
      8'h4A,8'h20,8'hE5,8'hFF,8'h68,8'h29,8'h0F,8'h09,
      8'hB0,8'hC9,8'hBA,8'h90,8'h02,8'h69,8'h06,8'h2C,
      8'h12,8'hD0,8'h30,8'hFB,8'h8D,8'h12,8'hD0,8'h60,
      8'h00,8'h00,8'h00,8'h0F,8'h00,8'hFF,8'h00,8'h00
   };

   localparam stim_row_type Directed [NumDirected] = '{
      '{'{mmpt_pkg::OpRead, mmpt_pkg::KbdDataAddr, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::KbdCtrlAddr, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::DispCtrlAddr, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::RomBase, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'hD8, 8'h00},
      '{'{mmpt_pkg::OpRead, 16'hFFFF, 8'hFF, 8'hFF},
        2'd1, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpRead, 16'hF010, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'hDF, 8'h00},
      '{'{mmpt_pkg::OpRead, 16'hC000, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpWrite, 16'h0000, 8'hFF, 8'h00},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpWrite, 16'hEFFF, 8'h00, 8'hFF},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpRead, 16'h0000, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'hFF, 8'h00},
      '{'{mmpt_pkg::OpRead, 16'hEFFF, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpWrite, mmpt_pkg::DispDataAddr, mmpt_pkg::CharCr, 8'h00},
        2'd2, mmpt_pkg::KindTerm, mmpt_pkg::OutCr, mmpt_pkg::OutLf},
      '{'{mmpt_pkg::OpWrite, mmpt_pkg::DispDataAddr, mmpt_pkg::CharRubout, 8'h00},
        2'd1, mmpt_pkg::KindTerm, mmpt_pkg::OutBs, 8'h00},
      '{'{mmpt_pkg::OpWrite, mmpt_pkg::DispDataAddr, 8'hFF, 8'h00},
        2'd1, mmpt_pkg::KindTerm, 8'h7F, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::DispDataAddr, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'h7F, 8'h00},
      '{'{mmpt_pkg::OpKey, 16'h0000, 8'h00, mmpt_pkg::CharLf},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpKey, 16'h0000, 8'h00, mmpt_pkg::CharBs},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::KbdCtrlAddr, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'h80, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::KbdDataAddr, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'hDF, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::KbdCtrlAddr, 8'h00, 8'h00},
        2'd1, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpKey, 16'h0000, 8'h00, mmpt_pkg::CharDel},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpWrite, mmpt_pkg::KbdCtrlAddr, 8'hAA, 8'h00},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpWrite, mmpt_pkg::DispCtrlAddr, 8'h55, 8'h00},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpWrite, 16'hF123, 8'h11, 8'h00},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::KbdDataAddr, 8'h00, 8'h00},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::KbdCtrlAddr, 8'h00, 8'h00},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{mmpt_pkg::OpRead, mmpt_pkg::DispCtrlAddr, 8'h00, 8'h00},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00},
      '{'{OpSpare, mmpt_pkg::DispDataAddr, 8'h41, 8'h41},
        2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00}
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   mmpt_pkg::req_type req_data  = '0;
   logic              rsp_pop   = 1'b0;
   logic              req_full;
   logic              rsp_empty;
   mmpt_pkg::rsp_type rsp_data;

   // mirror of the memory map
   logic [7:0]  low_mem [4096];
   logic [7:0]  high_mem [4096];
   bit          low_set [4096];
   bit          high_set [4096];
   logic [11:0] low_written [$];
   logic [11:0] high_written [$];
   logic [7:0]  key_data_reg    = '0;
   logic [7:0]  key_ctrl_reg    = '0;
   logic [7:0]  disp_data_reg   = '0;
   logic [7:0]  disp_ctrl_reg   = '0;

   mmpt_pkg::rsp_type pending_results [$];
   int                mismatch_count = 0;
   int                burst_left     = 0;

   memory_map_with_pia_terminal i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2000000;
      $display("[memory_map_with_pia_terminal] ERROR");
      $finish;
   end

   task automatic apply_bus_access(input mmpt_pkg::req_type acc, input bit record);
      logic [3:0]  page;
      logic [11:0] idx;
      logic [7:0]  rd;
      logic [7:0]  code;
      page = acc.bus_address[15:12];
      idx  = acc.bus_address[11:0];
      case (acc.opcode)
         mmpt_pkg::OpRead: begin
            rd = 8'h00;
            if (page == mmpt_pkg::PageLowRam) begin
               rd = low_mem[idx];
            end else if (page == mmpt_pkg::PageHighRam) begin
               rd = high_mem[idx];
            end else if (page == mmpt_pkg::PageRom) begin
               rd = RomImage[acc.bus_address[7:0]];
            end else begin
               case (acc.bus_address)
                  mmpt_pkg::KbdDataAddr: begin
                     rd = key_data_reg;
                     key_ctrl_reg = key_ctrl_reg & mmpt_pkg::Low7Mask;
                  end
                  mmpt_pkg::KbdCtrlAddr:  rd = key_ctrl_reg;
                  mmpt_pkg::DispDataAddr: rd = disp_data_reg;
                  mmpt_pkg::DispCtrlAddr: rd = disp_ctrl_reg;
                  default:                rd = 8'h00;
               endcase
            end
            if (record) pending_results.push_back('{mmpt_pkg::KindRead, rd, 1'b1});
         end
         mmpt_pkg::OpWrite: begin
            if (page == mmpt_pkg::PageLowRam) begin
               low_mem[idx] = acc.write_byte;
               if (!low_set[idx]) low_written.push_back(idx);
               low_set[idx] = 1'b1;
            end else if (page == mmpt_pkg::PageHighRam) begin
               high_mem[idx] = acc.write_byte;
               if (!high_set[idx]) high_written.push_back(idx);
               high_set[idx] = 1'b1;
            end else begin
               case (acc.bus_address)
                  mmpt_pkg::KbdDataAddr:  key_data_reg  = acc.write_byte;
                  mmpt_pkg::KbdCtrlAddr:  key_ctrl_reg  = acc.write_byte;
                  mmpt_pkg::DispCtrlAddr: disp_ctrl_reg = acc.write_byte;
                  mmpt_pkg::DispDataAddr: begin
                     disp_data_reg = acc.write_byte & mmpt_pkg::Low7Mask;
                     if (record) begin
                        if (acc.write_byte == mmpt_pkg::CharCr) begin
                           pending_results.push_back(
                              '{mmpt_pkg::KindTerm, mmpt_pkg::OutCr, 1'b0});
                           pending_results.push_back(
                              '{mmpt_pkg::KindTerm, mmpt_pkg::OutLf, 1'b1});
                        end else if (acc.write_byte == mmpt_pkg::CharRubout) begin
                           pending_results.push_back(
                              '{mmpt_pkg::KindTerm, mmpt_pkg::OutBs, 1'b1});
                        end else begin
                           pending_results.push_back('{mmpt_pkg::KindTerm,
                              acc.write_byte & mmpt_pkg::Low7Mask, 1'b1});
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         mmpt_pkg::OpKey: begin
            if (acc.key_code != mmpt_pkg::CharLf) begin
               code = acc.key_code;
               if (code == mmpt_pkg::CharBs || code == mmpt_pkg::CharDel) begin
                  code = mmpt_pkg::CharUnder;
               end
               key_data_reg = code | mmpt_pkg::StrobeBit;
               key_ctrl_reg = key_ctrl_reg | mmpt_pkg::StrobeBit;
            end
         end
         default: ;
      endcase
   endtask

   // bursts of pushes with random gaps; some long stretches without gaps
   task automatic pace();
      if (burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 12));
      end
      burst_left--;
   endtask

   task automatic send_item(input stim_row_type row);
      pace();
      req_push <= 1'b1;
      req_data <= row.req;
      do @(posedge clock); while (req_full);
      apply_bus_access(row.req, row.n_typed == 2'd0);
      if (row.n_typed == 2'd2) begin
         pending_results.push_back('{row.kind, row.byte0, 1'b0});
         pending_results.push_back('{row.kind, row.byte1, 1'b1});
      end else if (row.n_typed == 2'd1) begin
         pending_results.push_back('{row.kind, row.byte0, 1'b1});
      end
      @(negedge clock);
   endtask

   task automatic draw_access(output mmpt_pkg::req_type acc, output bit counts);
      int          sel;
      int          sub;
      logic [11:0] idx;
      logic [3:0]  page;
      bit          pick_low;
      sel = $urandom_range(0, 99);
      sub = $urandom_range(0, 9);
      idx = 12'($urandom_range(0, 4095));
      acc.bus_address = 16'($urandom_range(0, 65535));
      acc.write_byte  = 8'($urandom_range(0, 255));
      acc.key_code    = 8'($urandom_range(0, 255));
      counts = 1'b1;
      if (sel < 40) begin
         acc.opcode = mmpt_pkg::OpRead;
         if (sub < 4 && (low_written.size() != 0 || high_written.size() != 0)) begin
            pick_low = (high_written.size() == 0) ||
                       (low_written.size() != 0 && $urandom_range(0, 1) != 0);
            if (pick_low) begin
               acc.bus_address = {mmpt_pkg::PageLowRam,
                  low_written[$urandom_range(0, low_written.size() - 1)]};
            end else begin
               acc.bus_address = {mmpt_pkg::PageHighRam,
                  high_written[$urandom_range(0, high_written.size() - 1)]};
            end
         end else if (sub < 6) begin
            acc.bus_address = mmpt_pkg::KbdDataAddr + 16'($urandom_range(0, 3));
         end else if (sub < 8) begin
            acc.bus_address = {mmpt_pkg::PageRom, idx};
         end else begin
            page = 4'($urandom_range(1, 13));
            acc.bus_address = {page, idx};
         end
      end else if (sel < 80) begin
         acc.opcode = mmpt_pkg::OpWrite;
         if (sub < 4) begin
            acc.bus_address = {($urandom_range(0, 1) ? mmpt_pkg::PageHighRam
                                                     : mmpt_pkg::PageLowRam), idx};
         end else if (sub < 7) begin
            acc.bus_address = mmpt_pkg::DispDataAddr;
            case ($urandom_range(0, 3))
               0: acc.write_byte = mmpt_pkg::CharCr;
               1: acc.write_byte = mmpt_pkg::CharRubout;
               default: ;
            endcase
         end else if (sub < 8) begin
            case ($urandom_range(0, 2))
               0: acc.bus_address = mmpt_pkg::KbdDataAddr;
               1: acc.bus_address = mmpt_pkg::KbdCtrlAddr;
               default: acc.bus_address = mmpt_pkg::DispCtrlAddr;
            endcase
         end else begin
            page = $urandom_range(0, 1) ? mmpt_pkg::PageRom : 4'($urandom_range(1, 13));
            acc.bus_address = {page, idx};
            counts = 1'b0;
         end
      end else if (sel < 95) begin
         acc.opcode = mmpt_pkg::OpKey;
         case ($urandom_range(0, 5))
            0: acc.key_code = mmpt_pkg::CharLf;
            1: acc.key_code = mmpt_pkg::CharBs;
            2: acc.key_code = mmpt_pkg::CharDel;
            default: ;
         endcase
      end else begin
         acc.opcode = OpSpare;
         counts = 1'b0;
      end
   endtask

   // receiver stalls on a random duty pattern; its period and stall length are redrawn for each window
   initial begin
      int period;
      int stall_len;
      forever begin
         period    = $urandom_range(2, 9);
         stall_len = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, period - 1));
         for (int c = 0; c < 40; c++) begin
            @(negedge clock);
            rsp_pop <= ((c % period) >= stall_len);
         end
      end
   end

   always @(posedge clock) begin
      mmpt_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer: kind %0d byte %02h last %0d",
               rsp_data.result_kind, rsp_data.result_byte, rsp_data.last_of_run);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_kind !== want.result_kind) begin
               $error("result_kind: expected %0d, got %0d",
                  want.result_kind, rsp_data.result_kind);
               mismatch_count++;
            end
            if (rsp_data.result_byte !== want.result_byte) begin
               $error("result_byte: expected %02h, got %02h",
                  want.result_byte, rsp_data.result_byte);
               mismatch_count++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d",
                  want.last_of_run, rsp_data.last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type      row;
      mmpt_pkg::req_type acc;
      bit                counts;
      int                accesses_done;
      bit                drained;
      accesses_done = 0;
      drained       = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);

      for (int i = 0; i < NumDirected; i++) send_item(Directed[i]);

      // let the directed transfers drain before random traffic
      req_push <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);

      while (accesses_done < NumAccesses) begin
         if (accesses_done == NumAccesses / 2 && !drained) begin
            req_push <= 1'b0;
            do @(negedge clock); while (pending_results.size() != 0);
            drained = 1'b1;
         end
         draw_access(acc, counts);
         row = '{acc, 2'd0, mmpt_pkg::KindRead, 8'h00, 8'h00};
         send_item(row);
         if (counts) accesses_done++;
      end

      req_push <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      repeat (12) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[memory_map_with_pia_terminal] OK");
      end else begin
         $display("[memory_map_with_pia_terminal] ERROR");
      end
      $finish;
   end

endmodule
